>>> src/synth_voice_allocator_top_defines.svh
// ----------------------------------------------------------------------------
// Voice allocator assertion macros
// Shared macros for the concurrent checks of the voice allocator.
// ----------------------------------------------------------------------------
`ifndef SYNTH_VOICE_ALLOCATOR_TOP_DEFINES_SVH
`define SYNTH_VOICE_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SVA_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SVA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/sva_pkg.sv
// ----------------------------------------------------------------------------
// Voice allocator package
// Codes, command and status types shared by the allocator modules.
// ----------------------------------------------------------------------------
package sva_pkg;

	localparam logic [2:0] KIND_NOTE_ON  = 3'd0;
	localparam logic [2:0] KIND_NOTE_OFF = 3'd1;
	localparam logic [2:0] KIND_VOICE_END = 3'd2;
	localparam logic [2:0] KIND_LEVEL    = 3'd3;
	localparam logic [2:0] KIND_RESET    = 3'd4;

	localparam logic [2:0] CMD_NONE    = 3'd0;
	localparam logic [2:0] CMD_START   = 3'd1;
	localparam logic [2:0] CMD_RETUNE  = 3'd2;
	localparam logic [2:0] CMD_RELEASE = 3'd3;
	localparam logic [2:0] CMD_KILL    = 3'd4;

	localparam logic [1:0] GSRC_NONE  = 2'd0;
	localparam logic [1:0] GSRC_VOICE = 2'd1;
	localparam logic [1:0] GSRC_LAST  = 2'd2;

	localparam logic [1:0] MODE_POLY   = 2'd0;
	localparam logic [1:0] MODE_LEGATO = 2'd2;

	localparam logic [1:0] CFG_VOICE_MODE = 2'd0;
	localparam logic [1:0] CFG_GLIDE_ON   = 2'd1;

	localparam int          MAX_RESULTS = 16;
	localparam int          CNT_W       = 5;
	localparam logic [7:0]  NO_NOTE     = 8'hFF;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_LATCH,
		OP_HREM,
		OP_HPUSH,
		OP_FIND,
		OP_NEWEST,
		OP_RELOTH,
		OP_POLYOFF,
		OP_ON_ACT,
		OP_START_FOUND,
		OP_HTOP,
		OP_OFF_ACT,
		OP_KILL,
		OP_VEND,
		OP_VLVL,
		OP_FLUSH
	} dp_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HREM,
		ST_HPUSH,
		ST_FIND,
		ST_NEWEST,
		ST_RELOTH,
		ST_POLYOFF,
		ST_ON_ACT,
		ST_START_FOUND,
		ST_HTOP,
		ST_OFF_ACT,
		ST_KILL,
		ST_VEND,
		ST_VLVL,
		ST_FLUSH
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
		logic poly;
		logic v_found;
		logic pend_valid;
	} dp_stat_t;

	typedef struct packed {
		logic [2:0] command;
		logic [3:0] target_voice;
		logic [6:0] cmd_note;
		logic [6:0] cmd_velocity;
		logic [1:0] glide_source;
		logic [6:0] glide_note;
	} res_t;

endpackage

>>> src/synth_voice_allocator_top.sv
// Events are handled one item at a time. A note event runs the held-note removal pass
// (one stack entry a cycle) and the voice scans (one voice a cycle while the output does
// not stall); mono and legato modes scan the voices up to three times per event, poly
// mode once. Level, voice-end and reset events run no scan.
// Results leave one per cycle while the consumer keeps up; a stalled output stalls scans.
// Reset is asynchronous and active low; no clearing pass is needed after it.
// ----------------------------------------------------------------------------
// Voice allocator top level
// Polyphonic voice allocator with voice stealing, mono and legato modes.
// ----------------------------------------------------------------------------
`include "synth_voice_allocator_top_defines.svh"

module synth_voice_allocator_top #(
	parameter int NUM_VOICES = 16,
	parameter int HELD_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // note, velocity, voice_index, env_level, zero pad
	input  logic [2:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // target_voice, cmd_note, cmd_velocity, glide_source,
	                               // glide_note, zero pad
	output logic [2:0]  m_tuser,   // command
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_data
);
	import sva_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	res_t     res;

	sva_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_kind  (s_tuser),
		.cmd      (cmd),
		.stat     (stat)
	);

	sva_datapath #(
		.NUM_VOICES (NUM_VOICES),
		.HELD_DEPTH (HELD_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.in_note        (s_tdata[6:0]),
		.in_velocity    (s_tdata[13:7]),
		.in_voice_index (s_tdata[17:14]),
		.in_env_level   (s_tdata[33:18]),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_res        (res),
		.out_last       (m_tlast)
	);

	assign m_tuser = res.command;
	assign m_tdata = {5'd0, res.glide_note, res.glide_source, res.cmd_velocity,
	                  res.cmd_note, res.target_voice};

	`SVA_ASSERT_IMPL(a_idle_no_pending, s_tready, !stat.pend_valid, "result left pending at idle")
	`SVA_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "item taken while busy")
	`SVA_ASSERT_IMPL(a_no_empty_cmd, m_tvalid, m_tuser != CMD_NONE, "empty command emitted")

endmodule

>>> src/sva_ctrl.sv
// ----------------------------------------------------------------------------
// Voice allocator controller
// Sequences the datapath operations for each accepted event.
// ----------------------------------------------------------------------------
module sva_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [2:0]       in_kind,
	output sva_pkg::dp_cmd_t cmd,
	input  sva_pkg::dp_stat_t stat
);
	import sva_pkg::*;

	ctrl_state_t state_q, state_d;
	logic [2:0]  kind_q;
	logic        accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= KIND_NOTE_ON;
		end else begin
			state_q <= state_d;
			if (accept) begin
				kind_q <= in_kind;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (in_kind)
						KIND_NOTE_ON, KIND_NOTE_OFF: state_d = ST_HREM;
						KIND_VOICE_END: state_d = ST_VEND;
						KIND_LEVEL:     state_d = ST_VLVL;
						KIND_RESET:     state_d = ST_KILL;
						default:        state_d = ST_FLUSH;
					endcase
				end
			end
			ST_HREM: begin
				if (stat.done) begin
					if (kind_q == KIND_NOTE_ON) begin
						state_d = ST_HPUSH;
					end else begin
						state_d = stat.poly ? ST_POLYOFF : ST_NEWEST;
					end
				end
			end
			ST_HPUSH: state_d = stat.poly ? ST_FIND : ST_NEWEST;
			ST_FIND: begin
				if (stat.done) begin
					state_d = ST_START_FOUND;
				end
			end
			ST_NEWEST: begin
				if (stat.done) begin
					state_d = (kind_q == KIND_NOTE_ON) ? ST_RELOTH : ST_HTOP;
				end
			end
			ST_RELOTH: begin
				if (stat.done) begin
					state_d = stat.v_found ? ST_ON_ACT : ST_FIND;
				end
			end
			ST_HTOP: state_d = ST_OFF_ACT;
			ST_POLYOFF, ST_ON_ACT, ST_START_FOUND, ST_OFF_ACT, ST_KILL: begin
				if (stat.done) begin
					state_d = ST_FLUSH;
				end
			end
			ST_VEND, ST_VLVL: state_d = ST_FLUSH;
			ST_FLUSH: begin
				if (stat.done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = OP_IDLE;
		unique case (state_q)
			ST_IDLE:        cmd.op = accept ? OP_LATCH : OP_IDLE;
			ST_HREM:        cmd.op = OP_HREM;
			ST_HPUSH:       cmd.op = OP_HPUSH;
			ST_FIND:        cmd.op = OP_FIND;
			ST_NEWEST:      cmd.op = OP_NEWEST;
			ST_RELOTH:      cmd.op = OP_RELOTH;
			ST_POLYOFF:     cmd.op = OP_POLYOFF;
			ST_ON_ACT:      cmd.op = OP_ON_ACT;
			ST_START_FOUND: cmd.op = OP_START_FOUND;
			ST_HTOP:        cmd.op = OP_HTOP;
			ST_OFF_ACT:     cmd.op = OP_OFF_ACT;
			ST_KILL:        cmd.op = OP_KILL;
			ST_VEND:        cmd.op = OP_VEND;
			ST_VLVL:        cmd.op = OP_VLVL;
			ST_FLUSH:       cmd.op = OP_FLUSH;
			default:        cmd.op = OP_IDLE;
		endcase
	end

endmodule

>>> src/sva_datapath.sv
// ----------------------------------------------------------------------------
// Voice allocator datapath
// Voice table, held-note stack, voice scans and the result buffer.
// ----------------------------------------------------------------------------
module sva_datapath #(
	parameter int NUM_VOICES = 16,
	parameter int HELD_DEPTH = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sva_pkg::dp_cmd_t  cmd,
	output sva_pkg::dp_stat_t stat,
	input  logic [6:0]        in_note,
	input  logic [6:0]        in_velocity,
	input  logic [3:0]        in_voice_index,
	input  logic [15:0]       in_env_level,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [1:0]        cfg_data,
	output logic              out_valid,
	input  logic              out_ready,
	output sva_pkg::res_t     out_res,
	output logic              out_last
);
	import sva_pkg::*;

	localparam int VW  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int HCW = $clog2(HELD_DEPTH + 1);
	localparam int HIW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;

	logic [1:0]  mode_q;
	logic        glide_q;

	logic [6:0]  note_q;
	logic [6:0]  vel_q;
	logic [3:0]  vi_q;
	logic [15:0] lvl_q;

	logic        act_q  [NUM_VOICES];
	logic        rel_q  [NUM_VOICES];
	logic [6:0]  vnote_q[NUM_VOICES];
	logic [6:0]  vvel_q [NUM_VOICES];
	logic [31:0] age_q  [NUM_VOICES];
	logic [15:0] vlvl_q [NUM_VOICES];

	logic [31:0] age_ctr_q;
	logic [7:0]  lp_q;
	logic [HCW-1:0] hcnt_q;

	logic [VW-1:0] scan_q;
	logic          scan_first;
	logic          scan_last;
	logic          scanning;

	logic          fi_found_q, rb_found_q, nb_found_q;
	logic [VW-1:0] fi_idx_q, rb_idx_q, old_idx_q, nb_idx_q;
	logic [15:0]   rb_lvl_q;
	logic [31:0]   old_age_q, nb_age_q;
	logic          nb_rel_q;
	logic [6:0]    nb_note_q, nb_vel_q;
	logic          fi_f, rb_f, nb_f;
	logic [VW-1:0] find_idx;
	logic          off_ok;

	logic [6:0]     hs_mem[HELD_DEPTH];
	logic [6:0]     hs_rd_s1;
	logic [HIW-1:0] rd_idx_s1;
	logic           rd_v_s1;
	logic [HCW-1:0] rp_q;
	logic           hfound_q;
	logic           rd_en;
	logic [HIW-1:0] rd_addr;
	logic           hs_we;
	logic [HIW-1:0] hs_waddr;
	logic [6:0]     hs_wdata;
	logic           hrem_issue;
	logic           hrem_done;

	logic          emit_req;
	logic          scan_hit;
	logic          act_start, act_retune, act_release;
	logic [VW-1:0] act_v;
	logic [6:0]    act_note, act_vel;
	logic [1:0]    act_gsrc;
	res_t          res_new;
	logic          out_busy, go, fire, flush_move;

	res_t             pend_q;
	logic             pend_valid_q;
	res_t             out_q;
	logic             out_valid_q;
	logic             out_last_q;
	logic [CNT_W-1:0] cnt_q;

	logic          vi_ok;
	logic [VW-1:0] vi_idx;

	assign vi_ok  = (32'(vi_q) < NUM_VOICES);
	assign vi_idx = VW'(vi_q);

	assign scanning   = (cmd.op == OP_FIND) || (cmd.op == OP_NEWEST) ||
	                    (cmd.op == OP_RELOTH) || (cmd.op == OP_POLYOFF);
	assign scan_first = (scan_q == '0);
	assign scan_last  = (scan_q == VW'(NUM_VOICES - 1));

	assign fi_f = scan_first ? 1'b0 : fi_found_q;
	assign rb_f = scan_first ? 1'b0 : rb_found_q;
	assign nb_f = scan_first ? 1'b0 : nb_found_q;

	assign find_idx = fi_found_q ? fi_idx_q : (rb_found_q ? rb_idx_q : old_idx_q);
	assign off_ok   = nb_found_q && !nb_rel_q && (nb_note_q == note_q);

	assign out_busy = out_valid_q && !out_ready;

	// Configuration registers and event latch.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_POLY;
			glide_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VOICE_MODE: mode_q  <= cfg_data;
				CFG_GLIDE_ON:   glide_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LATCH) begin
			note_q <= in_note;
			vel_q  <= in_velocity;
			vi_q   <= in_voice_index;
			lvl_q  <= in_env_level;
		end
	end

	// Result selection for the current operation.
	always_comb begin
		emit_req    = 1'b0;
		scan_hit    = 1'b0;
		res_new     = '0;
		act_start   = 1'b0;
		act_retune  = 1'b0;
		act_release = 1'b0;
		act_v       = nb_idx_q;
		act_note    = note_q;
		act_vel     = vel_q;
		act_gsrc    = glide_q ? GSRC_VOICE : GSRC_NONE;
		unique case (cmd.op)
			OP_RELOTH: begin
				scan_hit = act_q[scan_q] && !rel_q[scan_q] &&
				           !(nb_found_q && (nb_idx_q == scan_q));
				emit_req = scan_hit && (cnt_q < CNT_W'(MAX_RESULTS - 1));
				res_new.command      = CMD_RELEASE;
				res_new.target_voice = 4'(scan_q);
			end
			OP_POLYOFF: begin
				scan_hit = act_q[scan_q] && !rel_q[scan_q] && (vnote_q[scan_q] == note_q);
				emit_req = scan_hit && (cnt_q < CNT_W'(MAX_RESULTS));
				res_new.command      = CMD_RELEASE;
				res_new.target_voice = 4'(scan_q);
			end
			OP_ON_ACT: begin
				if ((mode_q == MODE_LEGATO) && (hcnt_q > HCW'(1)) && !nb_rel_q) begin
					act_retune = 1'b1;
				end else begin
					act_start = 1'b1;
				end
			end
			OP_START_FOUND: begin
				act_v     = find_idx;
				act_start = 1'b1;
				if ((mode_q != MODE_POLY) && glide_q && (lp_q != NO_NOTE)) begin
					act_gsrc = GSRC_LAST;
				end else begin
					act_gsrc = GSRC_NONE;
				end
			end
			OP_OFF_ACT: begin
				act_note = hs_rd_s1;
				act_vel  = nb_vel_q;
				if (off_ok) begin
					if (hcnt_q != '0) begin
						if (mode_q == MODE_LEGATO) begin
							act_retune = 1'b1;
						end else begin
							act_start = 1'b1;
						end
					end else begin
						act_release = 1'b1;
					end
				end
			end
			OP_KILL: begin
				emit_req        = (cnt_q < CNT_W'(MAX_RESULTS));
				res_new.command = CMD_KILL;
			end
			default: ;
		endcase
		if (act_start || act_retune || act_release) begin
			emit_req             = (cnt_q < CNT_W'(MAX_RESULTS));
			res_new.target_voice = 4'(act_v);
			if (act_release) begin
				res_new.command = CMD_RELEASE;
			end else begin
				res_new.command      = act_start ? CMD_START : CMD_RETUNE;
				res_new.cmd_note     = act_note;
				res_new.cmd_velocity = act_start ? act_vel : 7'd0;
				res_new.glide_source = act_gsrc;
				res_new.glide_note   = (act_start && (act_gsrc == GSRC_LAST)) ? lp_q[6:0] : 7'd0;
			end
		end
	end

	assign go         = !(emit_req && pend_valid_q && out_busy);
	assign fire       = emit_req && go;
	assign flush_move = (cmd.op == OP_FLUSH) && pend_valid_q && !out_busy;

	// Voice table with reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VOICES; i++) begin
				act_q[i]  <= 1'b0;
				rel_q[i]  <= 1'b0;
				age_q[i]  <= '0;
				vlvl_q[i] <= '0;
			end
			age_ctr_q <= '0;
			lp_q      <= NO_NOTE;
		end else begin
			if ((cmd.op == OP_VEND) && vi_ok) begin
				act_q[vi_idx] <= 1'b0;
				rel_q[vi_idx] <= 1'b0;
			end
			if ((cmd.op == OP_VLVL) && vi_ok) begin
				vlvl_q[vi_idx] <= lvl_q;
			end
			if (cmd.op == OP_KILL) begin
				for (int i = 0; i < NUM_VOICES; i++) begin
					act_q[i] <= 1'b0;
					rel_q[i] <= 1'b0;
				end
				lp_q <= NO_NOTE;
			end
			if (scan_hit && go) begin
				rel_q[scan_q] <= 1'b1;
			end
			if (act_start && go) begin
				age_ctr_q     <= age_ctr_q + 32'd1;
				age_q[act_v]  <= age_ctr_q + 32'd1;
				act_q[act_v]  <= 1'b1;
				rel_q[act_v]  <= 1'b0;
			end
			if (act_release && go) begin
				rel_q[act_v] <= 1'b1;
			end
			if (((cmd.op == OP_ON_ACT) || (cmd.op == OP_START_FOUND)) && go) begin
				lp_q <= {1'b0, note_q};
			end
			if ((cmd.op == OP_OFF_ACT) && (act_start || act_retune) && go) begin
				lp_q <= {1'b0, hs_rd_s1};
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((act_start || act_retune) && go) begin
			vnote_q[act_v] <= act_note;
		end
		if (act_start && go) begin
			vvel_q[act_v] <= act_vel;
		end
	end

	// Voice scans: first free, quietest releasing, oldest and newest active.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q     <= '0;
			fi_found_q <= 1'b0;
			rb_found_q <= 1'b0;
			nb_found_q <= 1'b0;
		end else begin
			if (scanning && go) begin
				scan_q <= scan_last ? '0 : scan_q + 1'b1;
			end
			if (cmd.op == OP_FIND) begin
				fi_found_q <= fi_f || !act_q[scan_q];
				rb_found_q <= rb_f || rel_q[scan_q];
			end
			if (cmd.op == OP_NEWEST) begin
				nb_found_q <= nb_f || act_q[scan_q];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_FIND) begin
			if (!act_q[scan_q] && !fi_f) begin
				fi_idx_q <= scan_q;
			end
			if (rel_q[scan_q] && (!rb_f || (vlvl_q[scan_q] < rb_lvl_q))) begin
				rb_idx_q <= scan_q;
				rb_lvl_q <= vlvl_q[scan_q];
			end
			if (scan_first || (age_q[scan_q] < old_age_q)) begin
				old_idx_q <= scan_q;
				old_age_q <= age_q[scan_q];
			end
		end
		if (cmd.op == OP_NEWEST) begin
			if (act_q[scan_q] && (!nb_f || (age_q[scan_q] > nb_age_q))) begin
				nb_idx_q  <= scan_q;
				nb_age_q  <= age_q[scan_q];
				nb_rel_q  <= rel_q[scan_q];
				nb_note_q <= vnote_q[scan_q];
				nb_vel_q  <= vvel_q[scan_q];
			end
		end
	end

	// Held-note stack: removal streams through the memory and closes the gap.
	assign hrem_issue = (cmd.op == OP_HREM) && (rp_q < hcnt_q);
	assign hrem_done  = (cmd.op == OP_HREM) && (rp_q >= hcnt_q) && !rd_v_s1;
	assign rd_en      = hrem_issue || (cmd.op == OP_HTOP);
	assign rd_addr    = (cmd.op == OP_HTOP) ? HIW'(hcnt_q - HCW'(1)) : HIW'(rp_q);

	always_comb begin
		hs_we    = 1'b0;
		hs_waddr = HIW'(hcnt_q);
		hs_wdata = note_q;
		if ((cmd.op == OP_HREM) && rd_v_s1 && hfound_q) begin
			hs_we    = 1'b1;
			hs_waddr = rd_idx_s1 - HIW'(1);
			hs_wdata = hs_rd_s1;
		end else if ((cmd.op == OP_HPUSH) && (hcnt_q < HCW'(HELD_DEPTH))) begin
			hs_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (hs_we) begin
			hs_mem[hs_waddr] <= hs_wdata;
		end
		if (rd_en) begin
			hs_rd_s1 <= hs_mem[rd_addr];
		end
		rd_idx_s1 <= HIW'(rp_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q   <= '0;
			rp_q     <= '0;
			hfound_q <= 1'b0;
			rd_v_s1  <= 1'b0;
		end else begin
			rd_v_s1 <= hrem_issue;
			if (hrem_issue) begin
				rp_q <= rp_q + HCW'(1);
			end
			if ((cmd.op == OP_HREM) && rd_v_s1 && !hfound_q && (hs_rd_s1 == note_q)) begin
				hfound_q <= 1'b1;
			end
			if (hrem_done) begin
				hcnt_q   <= hcnt_q - HCW'(hfound_q);
				rp_q     <= '0;
				hfound_q <= 1'b0;
			end
			if ((cmd.op == OP_HPUSH) && (hcnt_q < HCW'(HELD_DEPTH))) begin
				hcnt_q <= hcnt_q + HCW'(1);
			end
			if (cmd.op == OP_KILL) begin
				hcnt_q <= '0;
			end
		end
	end

	// Result buffer: one pending item ahead of the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			cnt_q        <= '0;
		end else begin
			if (cmd.op == OP_LATCH) begin
				cnt_q <= '0;
			end
			if (fire) begin
				pend_valid_q <= 1'b1;
				cnt_q        <= cnt_q + CNT_W'(1);
			end
			if (fire && pend_valid_q) begin
				out_valid_q <= 1'b1;
			end else if (flush_move) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pend_q <= res_new;
		end
		if (fire && pend_valid_q) begin
			out_q      <= pend_q;
			out_last_q <= 1'b0;
		end else if (flush_move) begin
			out_q      <= pend_q;
			out_last_q <= 1'b1;
		end
	end

	always_comb begin
		stat.poly       = (mode_q == MODE_POLY);
		stat.v_found    = nb_found_q;
		stat.pend_valid = pend_valid_q;
		unique case (cmd.op)
			OP_HREM:   stat.done = hrem_done;
			OP_FIND, OP_NEWEST, OP_RELOTH, OP_POLYOFF: stat.done = go && scan_last;
			OP_ON_ACT, OP_START_FOUND, OP_OFF_ACT, OP_KILL: stat.done = go;
			OP_FLUSH:  stat.done = !pend_valid_q || !out_busy;
			OP_IDLE:   stat.done = 1'b0;
			default:   stat.done = 1'b1;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign out_last  = out_last_q;

endmodule

>>> test/tb_synth_voice_allocator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Voice allocator testbench
// Drives note on, note off, voice-ended, level and reset events through the
// input stream in poly, mono, legato and the spare mode, with and without
// glide. A scoreboard models the voice table, the held-key stack and the last
// played note, and compares every command item against its prediction.
// ----------------------------------------------------------------------------
module tb_synth_voice_allocator_top;
	import sva_pkg::*;

	localparam int NV        = 16;
	localparam int HD        = 128;
	localparam int DRAIN     = 400;
	localparam int WDOG_MAX  = 20000;

	typedef struct {
		res_t r;
		logic last;
	} cmd_exp_t;

	class voice_sb;
		logic [1:0]  mode;
		logic        glide;
		logic        act[NV];
		logic        rel[NV];
		logic [6:0]  vnote[NV];
		logic [6:0]  vvel[NV];
		logic [31:0] vage[NV];
		logic [15:0] vlvl[NV];
		logic [6:0]  stack[HD];
		int          held;
		logic [31:0] age_ctr;
		logic [7:0]  last_note;
		cmd_exp_t    exp_q[$];
		cmd_exp_t    pend[$];
		int          errors;
		int          checked;
		int          n_events;

		function new();
			mode = MODE_POLY;
			glide = 1'b0;
			for (int i = 0; i < NV; i++) begin
				act[i] = 0; rel[i] = 0; vnote[i] = 0; vvel[i] = 0;
				vage[i] = 0; vlvl[i] = 0;
			end
			for (int i = 0; i < HD; i++) stack[i] = 0;
			held = 0;
			age_ctr = 0;
			last_note = NO_NOTE;
			errors = 0;
			checked = 0;
			n_events = 0;
		endfunction

		function void set_cfg(logic [1:0] idx, logic [1:0] val);
			if (idx == CFG_VOICE_MODE) mode = val;
			else if (idx == CFG_GLIDE_ON) glide = val[0];
		endfunction

		function void emit(logic [2:0] cmd, int v, logic [6:0] nt, logic [6:0] vl,
		                   logic [1:0] gs, logic [6:0] gn);
			cmd_exp_t e;
			if (pend.size() >= MAX_RESULTS) return;
			e.r.command = cmd;
			e.r.target_voice = v[3:0];
			e.r.cmd_note = nt;
			e.r.cmd_velocity = vl;
			e.r.glide_source = gs;
			e.r.glide_note = gn;
			e.last = 1'b0;
			pend.push_back(e);
		endfunction

		function void release_v(int v, bit keep_slot);
			rel[v] = 1;
			if (!keep_slot || pend.size() < MAX_RESULTS - 1)
				emit(CMD_RELEASE, v, 0, 0, GSRC_NONE, 0);
		endfunction

		function void held_remove(logic [6:0] nt);
			for (int i = 0; i < held; i++) begin
				if (stack[i] == nt) begin
					for (int j = i; j + 1 < held; j++) stack[j] = stack[j + 1];
					held--;
					return;
				end
			end
		endfunction

		function void held_push(logic [6:0] nt);
			held_remove(nt);
			if (held < HD) begin
				stack[held] = nt;
				held++;
			end
		endfunction

		function int find_voice();
			int best;
			best = -1;
			for (int i = 0; i < NV; i++) if (!act[i]) return i;
			for (int i = 0; i < NV; i++)
				if (rel[i] && (best < 0 || vlvl[i] < vlvl[best])) best = i;
			if (best >= 0) return best;
			best = 0;
			for (int i = 0; i < NV; i++) if (vage[i] < vage[best]) best = i;
			return best;
		endfunction

		function int newest();
			int best;
			best = -1;
			for (int i = 0; i < NV; i++)
				if (act[i] && (best < 0 || vage[i] > vage[best])) best = i;
			return best;
		endfunction

		function void start_v(int v, logic [6:0] nt, logic [6:0] vl, logic [1:0] gs,
		                      logic [6:0] gn);
			age_ctr++;
			vage[v] = age_ctr;
			act[v] = 1;
			rel[v] = 0;
			vnote[v] = nt;
			vvel[v] = vl;
			emit(CMD_START, v, nt, vl, gs, (gs == GSRC_LAST) ? gn : 7'd0);
		endfunction

		function void retune_v(int v, logic [6:0] nt);
			vnote[v] = nt;
			emit(CMD_RETUNE, v, nt, 0, glide ? GSRC_VOICE : GSRC_NONE, 0);
		endfunction

		function void on_note(logic [6:0] nt, logic [6:0] vl);
			int v;
			logic [1:0] gs;
			held_push(nt);
			if (mode == MODE_POLY) begin
				start_v(find_voice(), nt, vl, GSRC_NONE, 0);
				last_note = {1'b0, nt};
				return;
			end
			v = newest();
			for (int i = 0; i < NV; i++)
				if (act[i] && i != v && !rel[i]) release_v(i, 1);
			if (v >= 0) begin
				if (mode == MODE_LEGATO && held > 1 && !rel[v]) retune_v(v, nt);
				else start_v(v, nt, vl, glide ? GSRC_VOICE : GSRC_NONE, 0);
			end else begin
				gs = (glide && last_note != NO_NOTE) ? GSRC_LAST : GSRC_NONE;
				start_v(find_voice(), nt, vl, gs, last_note[6:0]);
			end
			last_note = {1'b0, nt};
		endfunction

		function void off_note(logic [6:0] nt);
			int v;
			logic [6:0] back;
			held_remove(nt);
			if (mode == MODE_POLY) begin
				for (int i = 0; i < NV; i++)
					if (act[i] && vnote[i] == nt && !rel[i]) release_v(i, 0);
				return;
			end
			v = newest();
			if (v < 0 || rel[v] || vnote[v] != nt) return;
			if (held > 0) begin
				back = stack[held - 1];
				if (mode == MODE_LEGATO) retune_v(v, back);
				else start_v(v, back, vvel[v], glide ? GSRC_VOICE : GSRC_NONE, 0);
				last_note = {1'b0, back};
			end else begin
				release_v(v, 0);
			end
		endfunction

		function void note_event(logic [2:0] kind, logic [6:0] nt, logic [6:0] vl,
		                         logic [3:0] vi, logic [15:0] lvl);
			pend.delete();
			n_events++;
			case (kind)
				KIND_NOTE_ON:  on_note(nt, vl);
				KIND_NOTE_OFF: off_note(nt);
				KIND_VOICE_END: begin
					act[vi] = 0;
					rel[vi] = 0;
				end
				KIND_LEVEL: vlvl[vi] = lvl;
				KIND_RESET: begin
					for (int i = 0; i < NV; i++) begin
						act[i] = 0;
						rel[i] = 0;
					end
					held = 0;
					last_note = NO_NOTE;
					emit(CMD_KILL, 0, 0, 0, GSRC_NONE, 0);
				end
				default: ;
			endcase
			if (pend.size() > 0) pend[pend.size() - 1].last = 1'b1;
			foreach (pend[i]) exp_q.push_back(pend[i]);
		endfunction

		function void cmp(string name, int e, int a);
			if (e != a) begin
				$error("%s: expected %0d, got %0d", name, e, a);
				errors++;
			end
		endfunction

		function void check_result(logic [2:0] cmd, logic [31:0] d, logic lst);
			cmd_exp_t e;
			if (exp_q.size() == 0) begin
				$error("command item with nothing expected: command %0d", cmd);
				errors++;
				return;
			end
			e = exp_q.pop_front();
			checked++;
			cmp("command", e.r.command, cmd);
			cmp("target_voice", e.r.target_voice, d[3:0]);
			cmp("cmd_note", e.r.cmd_note, d[10:4]);
			cmp("cmd_velocity", e.r.cmd_velocity, d[17:11]);
			cmp("glide_source", e.r.glide_source, d[19:18]);
			cmp("glide_note", e.r.glide_note, d[26:20]);
			cmp("last", e.last, lst);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [1:0]  cfg_data;

	voice_sb sb;
	bit      tx_idle;
	bit      rx_stall;
	int      idle_pct;
	int      wdog;
	logic [6:0] base_note;

	synth_voice_allocator_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tx_idle = 0;
		rx_stall = 0;
		idle_pct = 84;
		wdog = 0;
	end

	always @(posedge clk) begin
		if (!arst_n) m_tready <= 1'b0;
		else m_tready <= rx_stall ? ($urandom_range(99) >= idle_pct) : 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) wdog <= 0;
		else wdog <= wdog + 1;
		if (wdog >= WDOG_MAX) begin
			$display("watchdog expired, %0d items still expected", sb.exp_q.size());
			$display("tb_synth_voice_allocator_top: done, errors");
			$finish;
		end
	end

	task automatic send(logic [2:0] kind, logic [6:0] nt, logic [6:0] vl, logic [3:0] vi,
	                    logic [15:0] lvl);
		s_tuser <= kind;
		s_tdata <= {6'd0, lvl, vi, vl, nt};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_event(kind, nt, vl, vi, lvl);
		if (tx_idle && $urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.exp_q.size() > 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_cfg(idx, val);
		@(posedge clk);
	endtask

	task automatic random_item();
		int k;
		logic [6:0] nt;
		k = $urandom_range(99);
		nt = ($urandom_range(99) < 80) ? base_note + 7'($urandom_range(7)) : 7'($urandom);
		if (k < 38)      send(KIND_NOTE_ON, nt, 7'($urandom), 4'($urandom), 16'($urandom));
		else if (k < 68) send(KIND_NOTE_OFF, nt, 7'($urandom), 4'($urandom), 16'($urandom));
		else if (k < 78) send(KIND_VOICE_END, 7'($urandom), 7'($urandom), 4'($urandom),
		                      16'($urandom));
		else if (k < 92) send(KIND_LEVEL, 7'($urandom), 7'($urandom), 4'($urandom),
		                      16'($urandom));
		else if (k < 95) send(KIND_RESET, 7'($urandom), 7'($urandom), 4'($urandom),
		                      16'($urandom));
		else send(3'($urandom_range(7, 5)), 7'($urandom), 7'($urandom), 4'($urandom),
		          16'($urandom));
	endtask

	initial begin
		logic [1:0] modes[8];
		logic       glides[8];
		modes = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0, 2'd3};
		glides = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};
		base_note = 7'd60;
		#1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, stealing, kinds outside the decoded set.
		write_cfg(CFG_VOICE_MODE, MODE_POLY);
		write_cfg(CFG_GLIDE_ON, 2'd0);
		send(KIND_NOTE_ON, 7'd0, 7'd0, 4'd0, 16'd0);
		send(KIND_NOTE_ON, 7'd127, 7'd127, 4'd15, 16'hFFFF);
		send(KIND_LEVEL, 7'd0, 7'd0, 4'd15, 16'hFFFF);
		send(KIND_LEVEL, 7'd0, 7'd0, 4'd0, 16'd0);
		for (int i = 0; i < 16; i++) send(KIND_NOTE_ON, 7'(40 + i), 7'(i * 8), 4'd0, 16'd0);
		send(KIND_NOTE_OFF, 7'd127, 7'd0, 4'd0, 16'd0);
		send(KIND_NOTE_ON, 7'd90, 7'd64, 4'd0, 16'd0);
		send(KIND_VOICE_END, 7'd0, 7'd0, 4'd3, 16'd0);
		send(KIND_NOTE_ON, 7'd91, 7'd1, 4'd0, 16'd0);
		send(3'd5, 7'd1, 7'd1, 4'd1, 16'd1);
		send(3'd7, 7'd127, 7'd127, 4'd15, 16'hFFFF);
		send(KIND_RESET, 7'd0, 7'd0, 4'd0, 16'd0);
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			write_cfg(CFG_VOICE_MODE, modes[ph]);
			write_cfg(CFG_GLIDE_ON, {1'($urandom), glides[ph]});
			tx_idle = (ph % 4 == 1) || (ph % 4 == 3);
			rx_stall = (ph % 4 == 2) || (ph % 4 == 3);
			idle_pct = (ph % 4 == 3) ? 29 : 84;
			if (ph == 3) begin
				// Hold every key so the held stack fills, then press a held key again and release two.
				for (int n = 0; n < 128; n++)
					send(KIND_NOTE_ON, 7'(n), 7'($urandom), 4'($urandom), 16'($urandom));
				send(KIND_NOTE_ON, 7'd5, 7'd100, 4'd0, 16'd0);
				send(KIND_NOTE_OFF, 7'd5, 7'd0, 4'd0, 16'd0);
				send(KIND_NOTE_OFF, 7'd127, 7'd0, 4'd0, 16'd0);
				send(KIND_RESET, 7'd0, 7'd0, 4'd0, 16'd0);
			end
			for (int i = 0; i < 40; i++) begin
				if ($urandom_range(9) == 0) base_note = 7'($urandom_range(120));
				random_item();
			end
			settle();
		end
		tx_idle = 0;
		rx_stall = 0;
		settle();

		$display("covered %0d events and %0d command items over eight mode/glide settings",
		         sb.n_events, sb.checked);
		$display("idle patterns: none, sender gaps, receiver stalls, both together");
		if (sb.errors == 0 && sb.exp_q.size() == 0) begin
			$display("tb_synth_voice_allocator_top: done, clean");
		end else begin
			$display("tb_synth_voice_allocator_top: done, errors");
		end
		$finish;
	end
endmodule
